// ===== hw/rtl/pwfc_pkg.sv =====
// Shared constants, types and helpers for the PLL word / frequency codec.
package pwfc_pkg;

	localparam int unsigned MAX_FREQ   = 6132;
	localparam int unsigned FB_W       = 9;
	localparam int unsigned PRE_W      = 5;
	localparam int unsigned POST_W     = 2;
	localparam int unsigned FREQ_W     = 13;
	localparam int unsigned NUM_W      = 14;
	localparam int unsigned DIV_STEPS  = 7;
	localparam int unsigned CAND_N     = 12;
	localparam logic [15:0] RECIP3     = 16'd43691;

	localparam logic [0:0] ACT_ENCODE = 1'b0;
	localparam logic [0:0] ACT_DECODE = 1'b1;

	// partial remainder and dividend/quotient shift word of the restoring divider
	typedef struct packed {
		logic [PRE_W-1:0] rem;
		logic [NUM_W-1:0] num;
	} div_t;

	// residue mod 3 of a 13-bit value: 4^k = 1 mod 3, so fold 2-bit digits
	function automatic logic [1:0] mod3(input logic [FREQ_W-1:0] v);
		logic [13:0] x;
		logic [4:0]  s;
		logic [2:0]  t;
		logic [2:0]  u;
		x = {1'b0, v};
		s = '0;
		for (int i = 0; i < 7; i++) begin
			s = s + {3'd0, x[2*i +: 2]};
		end
		t = {2'd0, s[4]} + {1'b0, s[3:2]} + {1'b0, s[1:0]};
		u = {2'd0, t[2]} + {1'b0, t[1:0]};
		if (u == 3'd3) begin
			return 2'd0;
		end else if (u == 3'd4) begin
			return 2'd1;
		end else begin
			return u[1:0];
		end
	endfunction

endpackage

// ===== hw/rtl/pwfc_div_steps.sv =====
// Seven restoring-division steps on the decode path.
module pwfc_div_steps (
	input  pwfc_pkg::div_t              din,
	input  logic [pwfc_pkg::PRE_W-1:0]  divisor,
	output pwfc_pkg::div_t              dout
);

	always_comb begin
		logic [pwfc_pkg::PRE_W:0] t;
		pwfc_pkg::div_t           d;
		d = din;
		for (int i = 0; i < pwfc_pkg::DIV_STEPS; i++) begin
			t = {d.rem, d.num[pwfc_pkg::NUM_W-1]};
			if (t >= {1'b0, divisor}) begin
				t     = t - {1'b0, divisor};
				d.num = {d.num[pwfc_pkg::NUM_W-2:0], 1'b1};
			end else begin
				d.num = {d.num[pwfc_pkg::NUM_W-2:0], 1'b0};
			end
			d.rem = t[pwfc_pkg::PRE_W-1:0];
		end
		dout = d;
	end

endmodule

// ===== hw/rtl/pll_word_frequency_codec.sv =====
// Top level of the PLL word / frequency codec.
// An accepted request is registered in stages 1, 2 and 3, then in the output register.
// Throughput: one request per cycle; a stalled output freezes the whole pipe.
// Encode: 12-way candidate search, one 13x16 multiply; decode: 14-step divide
// split over two stages.
// Reset clears all valid bits; payload registers are not reset.
module pll_word_frequency_codec (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] answer,
	output logic        error
);

	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1 signals
	logic                            v_s1, act_s1, err_s1;
	logic [pwfc_pkg::FREQ_W-1:0]     f_s1;
	logic [1:0]                      m3_s1;
	pwfc_pkg::div_t                  dv_s1;
	logic [pwfc_pkg::PRE_W-1:0]      pre_s1;
	logic [pwfc_pkg::POST_W-1:0]     post_s1;

	// stage 2
	logic                            v_s2, act_s2, err_s2, m3z_s2;
	logic [pwfc_pkg::FREQ_W-1:0]     g_s2;
	pwfc_pkg::div_t                  dv_s2;
	logic [pwfc_pkg::PRE_W-1:0]      pre_s2;
	logic [pwfc_pkg::POST_W-1:0]     post_s2;

	// stage 3
	logic                            v_s3, act_s3, err_s3, m3z_s3;
	logic [pwfc_pkg::FREQ_W-1:0]     g_s3;
	logic [11:0]                     q3_s3;
	pwfc_pkg::div_t                  dv_s3;
	logic [pwfc_pkg::POST_W-1:0]     post_s3;

	// stage 1 combinational
	logic                        in_err;
	logic [pwfc_pkg::FB_W-1:0]   in_fb;
	logic [pwfc_pkg::PRE_W-1:0]  in_pre;
	logic [pwfc_pkg::POST_W-1:0] in_post;
	pwfc_pkg::div_t              in_dv;

	always_comb begin
		in_post = value[15:14];
		in_pre  = value[13:9];
		in_fb   = value[8:0];
		if (action == pwfc_pkg::ACT_DECODE) begin
			in_err = (in_pre == '0) || (in_post == '0);
		end else begin
			in_err = (value == 16'd0) || (value > 16'(pwfc_pkg::MAX_FREQ));
		end
		in_dv.rem = '0;
		// 12*fb = 8*fb + 4*fb
		in_dv.num = {2'd0, in_fb, 3'd0} + {3'd0, in_fb, 2'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1  <= action;
			err_s1  <= in_err;
			f_s1    <= value[pwfc_pkg::FREQ_W-1:0];
			m3_s1   <= pwfc_pkg::mod3(value[pwfc_pkg::FREQ_W-1:0]);
			dv_s1   <= in_dv;
			pre_s1  <= (in_pre == '0) ? pwfc_pkg::PRE_W'(1) : in_pre;
			post_s1 <= in_post;
		end
	end

	// stage 2: pick the largest g <= f whose feedback value fits, plus 7 divide steps
	pwfc_pkg::div_t              dv_a;
	logic [pwfc_pkg::FREQ_W-1:0] g_sel;
	logic                        m3z_sel;

	pwfc_div_steps u_div_a (
		.din     (dv_s1),
		.divisor (pre_s1),
		.dout    (dv_a)
	);

	always_comb begin
		logic [pwfc_pkg::FREQ_W-1:0] g;
		logic [1:0]                  r;
		logic                        ok;
		g_sel   = f_s1;
		m3z_sel = (m3_s1 == 2'd0);
		for (int d = pwfc_pkg::CAND_N - 1; d >= 0; d--) begin
			g = f_s1 - pwfc_pkg::FREQ_W'(d);
			r = m3_s1;
			for (int k = 0; k < d % 3; k++) begin
				r = (r == 2'd0) ? 2'd2 : r - 2'd1;
			end
			if (r == 2'd0) begin
				ok = (g <= 13'd1535) || (!g[0] && g <= 13'd3071) ||
					(g[1:0] == 2'd0 && g <= 13'd6143);
			end else begin
				ok = (g <= 13'd511) || (!g[0] && g <= 13'd1023) ||
					(g[1:0] == 2'd0 && g <= 13'd2047);
			end
			if (ok) begin
				g_sel   = g;
				m3z_sel = (r == 2'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2  <= act_s1;
			err_s2  <= err_s1;
			g_s2    <= g_sel;
			m3z_s2  <= m3z_sel;
			dv_s2   <= dv_a;
			pre_s2  <= pre_s1;
			post_s2 <= post_s1;
		end
	end

	// stage 3: exact g/3 by reciprocal multiply, remaining divide steps
	pwfc_pkg::div_t dv_b;
	logic [28:0]    prod;

	pwfc_div_steps u_div_b (
		.din     (dv_s2),
		.divisor (pre_s2),
		.dout    (dv_b)
	);

	assign prod = 29'(g_s2) * 29'(pwfc_pkg::RECIP3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s3  <= act_s2;
			err_s3  <= err_s2;
			g_s3    <= g_s2;
			m3z_s3  <= m3z_s2;
			q3_s3   <= prod[28:17];
			dv_s3   <= dv_b;
			post_s3 <= post_s2;
		end
	end

	// stage 4: pack word or scale quotient
	logic [15:0]                 res;
	logic [pwfc_pkg::FREQ_W-1:0] fbp;
	logic [pwfc_pkg::FREQ_W-1:0] fbo;
	logic [pwfc_pkg::POST_W-1:0] pcode;
	logic [pwfc_pkg::PRE_W-1:0]  pre_e;
	logic [pwfc_pkg::NUM_W-1:0]  qsh;

	always_comb begin
		fbp   = m3z_s3 ? {1'b0, q3_s3} : g_s3;
		pre_e = m3z_s3 ? pwfc_pkg::PRE_W'(1) : pwfc_pkg::PRE_W'(3);
		if (fbp[1:0] == 2'd0) begin
			fbo   = fbp >> 2;
			pcode = 2'd1;
		end else if (!fbp[0]) begin
			fbo   = fbp >> 1;
			pcode = 2'd2;
		end else begin
			fbo   = fbp;
			pcode = 2'd3;
		end
		qsh = dv_s3.num >> (post_s3 - 2'd1);
		if (err_s3) begin
			res = '0;
		end else if (act_s3 == pwfc_pkg::ACT_DECODE) begin
			res = {2'd0, qsh};
		end else begin
			res = {pcode, pre_e, fbo[pwfc_pkg::FB_W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			answer <= res;
			error  <= err_s3;
		end
	end

endmodule

// ===== tb/tb_pll_word_frequency_codec.sv =====
// Testbench for the PLL word / frequency codec: queued driver, monitor with predictor.
module tb_pll_word_frequency_codec;

	typedef struct {
		logic        action;
		logic [15:0] value;
	} req_t;

	typedef struct {
		logic [15:0] answer;
		logic        error;
	} conv_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [15:0] value;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] answer;
	logic        error;

	req_t  pending_reqs[$];
	conv_t expected_convs[$];
	bit    feeding_done;
	int    fail_count;
	int    hold_count;
	int    out_gap;
	int    in_gap;
	// sampled stall at the last rising edge decides whether the request was taken
	logic  in_stall_s;

	pll_word_frequency_codec dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.action(action), .value(value), .out_valid(out_valid), .out_stall(out_stall),
		.answer(answer), .error(error)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic conv_t word_from_mhz(input logic [15:0] mhz);
		conv_t r;
		int unsigned f, post, pre, fb;
		r.answer = '0;
		r.error = 1'b1;
		f = 32'(mhz);
		if (f == 0 || f > pwfc_pkg::MAX_FREQ) return r;
		r.error = 1'b0;
		forever begin
			post = 3;
			pre = 3;
			fb = f / 3;
			if (fb * 3 == f) pre = 1;
			else fb = f;
			if ((fb & 3) == 0) begin
				fb = fb >> 2;
				post = 1;
			end else if ((fb & 1) == 0) begin
				fb = fb >> 1;
				post = 2;
			end
			if (fb <= 511 || f <= 1) break;
			f--;
		end
		r.answer = {post[1:0], pre[4:0], fb[8:0]};
		return r;
	endfunction

	function automatic conv_t mhz_from_word(input logic [15:0] w);
		conv_t r;
		int unsigned post, pre, fb;
		post = 32'(w[15:14]);
		pre = 32'(w[13:9]);
		fb = 32'(w[8:0]);
		r.answer = '0;
		r.error = 1'b1;
		if (pre == 0 || post == 0) return r;
		r.error = 1'b0;
		r.answer = 16'(((12 * fb) / pre) >> (post - 1));
		return r;
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// driver: changes inputs on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall_s) begin
				expected_convs.push_back(action == pwfc_pkg::ACT_ENCODE ?
					word_from_mhz(value) : mhz_from_word(value));
			end
			if (in_valid && in_stall_s) begin
				// request still pending, hold it
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req_t r;
				r = pending_reqs.pop_front();
				action <= r.action;
				value <= r.value;
				in_valid <= 1'b1;
				in_gap <= rand_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) in_stall_s <= in_stall;

	// receiver stall control and long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_count > 0) begin
				hold_count <= hold_count - 1;
				out_stall <= 1'b1;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				out_gap <= rand_gap();
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_convs.size() == 0) begin
				$display("%0t: result with none expected: answer %h error %b",
					$time, answer, error);
				fail_count++;
			end else begin
				conv_t e;
				e = expected_convs.pop_front();
				if (answer !== e.answer) begin
					$display("%0t: answer expected %h actual %h", $time, e.answer, answer);
					fail_count++;
				end
				if (error !== e.error) begin
					$display("%0t: error expected %b actual %b", $time, e.error, error);
					fail_count++;
				end
			end
		end
	end

	task automatic add_req(input logic a, input logic [15:0] v);
		req_t r;
		r.action = a;
		r.value = v;
		pending_reqs.push_back(r);
	endtask

	initial begin
		logic [15:0] v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = pwfc_pkg::ACT_ENCODE;
		value = '0;
		out_stall = 1'b0;
		in_stall_s = 1'b1;
		hold_count = 0;
		out_gap = 0;
		in_gap = 0;
		fail_count = 0;
		// directed: range edges, divisibility, factors of two, divider fields zero
		add_req(pwfc_pkg::ACT_ENCODE, 16'd0);
		add_req(pwfc_pkg::ACT_ENCODE, 16'd1);
		add_req(pwfc_pkg::ACT_ENCODE, 16'd2);
		add_req(pwfc_pkg::ACT_ENCODE, 16'd3);
		add_req(pwfc_pkg::ACT_ENCODE, 16'd4);
		add_req(pwfc_pkg::ACT_ENCODE, 16'd511);
		add_req(pwfc_pkg::ACT_ENCODE, 16'd513);
		add_req(pwfc_pkg::ACT_ENCODE, 16'd6131);
		add_req(pwfc_pkg::ACT_ENCODE, 16'd6132);
		add_req(pwfc_pkg::ACT_ENCODE, 16'd6133);
		add_req(pwfc_pkg::ACT_ENCODE, 16'hffff);
		add_req(pwfc_pkg::ACT_ENCODE, 16'd1021);
		add_req(pwfc_pkg::ACT_DECODE, 16'h0000);
		add_req(pwfc_pkg::ACT_DECODE, 16'hffff);
		add_req(pwfc_pkg::ACT_DECODE, 16'h01ff);
		add_req(pwfc_pkg::ACT_DECODE, 16'hc1ff);
		add_req(pwfc_pkg::ACT_DECODE, 16'h4200);
		add_req(pwfc_pkg::ACT_DECODE, 16'h43ff);
		add_req(pwfc_pkg::ACT_DECODE, 16'h83ff);
		add_req(pwfc_pkg::ACT_DECODE, 16'hfe00);
		add_req(pwfc_pkg::ACT_DECODE, 16'h7fff);
		for (int i = 0; i < 1050; i++) begin
			case ($urandom_range(0, 5))
				0: v = 16'($urandom_range(1, 64));
				1: v = 16'($urandom_range(1, pwfc_pkg::MAX_FREQ));
				2: v = 16'($urandom_range(pwfc_pkg::MAX_FREQ - 200, pwfc_pkg::MAX_FREQ + 5));
				default: v = 16'($urandom);
			endcase
			if ($urandom_range(0, 1) == 0) begin
				add_req(pwfc_pkg::ACT_ENCODE, v % 16'(pwfc_pkg::MAX_FREQ + 2));
			end else begin
				add_req(pwfc_pkg::ACT_DECODE, 16'($urandom));
			end
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// long receiver hold-off while requests keep coming
		repeat (300) @(posedge clk);
		@(negedge clk);
		hold_count = 60;
		wait (pending_reqs.size() == 0 && !in_valid);
		wait (expected_convs.size() == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_convs.size() == 0) begin
			$display("tb_pll_word_frequency_codec OK");
		end else begin
			$display("tb_pll_word_frequency_codec NOT OK");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_pll_word_frequency_codec NOT OK");
		$finish;
	end

endmodule

// ===== pll_word_frequency_codec.f =====
hw/rtl/pwfc_pkg.sv
hw/rtl/pwfc_div_steps.sv
hw/rtl/pll_word_frequency_codec.sv
tb/tb_pll_word_frequency_codec.sv
